### rtl/gdfw_pkg.sv
// Shared constants and result codes for the depth-first graph walker.
`default_nettype none

package gdfw_pkg;

  localparam int MaxNodes   = 64;
  localparam int MaxEntries = 256;

  localparam int NodeW     = $clog2(MaxNodes);
  localparam int CountW    = NodeW + 1;
  localparam int EntAddrW  = $clog2(MaxEntries);
  localparam int PosW      = EntAddrW + 1;
  localparam int EntryW    = PosW + NodeW;
  localparam int FrameW    = NodeW + PosW;

  localparam logic [PosW-1:0] EmptyPos = PosW'(MaxEntries);

  localparam logic [1:0] OpAddEdge = 2'd0;
  localparam logic [1:0] OpWalk    = 2'd1;
  localparam logic [1:0] OpClear   = 2'd2;

  localparam logic [1:0] KindVisit = 2'd0;
  localparam logic [1:0] KindDone  = 2'd1;
  localparam logic [1:0] KindRange = 2'd2;
  localparam logic [1:0] KindFull  = 2'd3;

endpackage

`default_nettype wire

### rtl/gdfw_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
`default_nettype none

module gdfw_ram #(
  parameter int DataW = 8,
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/graph_depth_first_walk.sv
// Top level of the adjacency-list graph store with a depth-first walk engine.
//
// A request on the input channel carries an op and two vertex numbers. Adding
// an edge returns one status result. Clearing the graph returns one status
// result. A walk returns one result per reached vertex, the final one marked
// by last_o; the registered read ports of the entry, head and stack memories
// set the pace of the walk. Only one request is in work at a time; in_ready_o
// is low until its last result has been loaded into the output register.
// Results sit in an output register. When the receiver stalls, the walk holds
// at the next found vertex until the register frees, and nothing is lost.
// The vertex count register is written through the configuration channel,
// which is always ready and must be used only while the block is idle.
// Reset empties the graph, sets the vertex count to 64 and drops any result.
`default_nettype none

module graph_depth_first_walk (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [gdfw_pkg::CountW-1:0]  cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   op_i,
  input  wire logic [gdfw_pkg::NodeW-1:0]   first_vertex_i,
  input  wire logic [gdfw_pkg::NodeW-1:0]   second_vertex_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [gdfw_pkg::NodeW-1:0]   vertex_o,
  output logic      [1:0]                   kind_o,
  output logic                              last_o
);

  import gdfw_pkg::*;

  typedef enum logic [3:0] {
    StIdle,
    StEdgeA,
    StEdgeB,
    StResp,
    StPushWait,
    StStep,
    StEntWait,
    StPopWait,
    StFinish
  } state_e;

  state_e state_q;

  logic [CountW-1:0]   vcount_q;
  logic [PosW-1:0]     used_q;
  logic [MaxNodes-1:0] head_vld_q;
  logic                head_rdv_q;
  logic [MaxNodes-1:0] visited_q;
  logic [NodeW-1:0]    a_q;
  logic [NodeW-1:0]    b_q;
  logic                same_q;
  logic [1:0]          resp_kind_q;
  logic [NodeW-1:0]    pend_q;
  logic [CountW-1:0]   count_q;
  logic [CountW-1:0]   depth_q;
  logic [NodeW-1:0]    new_v_q;
  logic [NodeW-1:0]    top_node_q;
  logic [PosW-1:0]     top_pos_q;
  logic                out_valid_q;
  logic [NodeW-1:0]    out_vertex_q;
  logic [1:0]          out_kind_q;
  logic                out_last_q;

  logic                head_we;
  logic [NodeW-1:0]    head_waddr;
  logic [PosW-1:0]     head_wdata;
  logic                head_re;
  logic [NodeW-1:0]    head_raddr;
  logic [PosW-1:0]     head_rdata;
  logic [PosW-1:0]     head_val;

  logic                ent_we;
  logic [EntAddrW-1:0] ent_waddr;
  logic [EntryW-1:0]   ent_wdata;
  logic                ent_re;
  logic [EntryW-1:0]   ent_rdata;
  logic [PosW-1:0]     ent_next;
  logic [NodeW-1:0]    ent_nb;

  logic                stk_we;
  logic                stk_re;
  logic [NodeW-1:0]    stk_raddr;
  logic [FrameW-1:0]   stk_rdata;

  logic                in_fire;
  logic                a_ok;
  logic                b_ok;
  logic                full;
  logic                out_free;
  logic                take_nb;
  logic [CountW-1:0]   depth_m1;
  logic [CountW-1:0]   depth_m2;
  logic [PosW-1:0]     used_p1;
  logic [PosW-1:0]     head_b;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;

  assign a_ok     = {1'b0, first_vertex_i} < vcount_q;
  assign b_ok     = {1'b0, second_vertex_i} < vcount_q;
  assign full     = used_q > PosW'(MaxEntries - 2);
  assign out_free = !out_valid_q || out_ready_i;
  assign used_p1  = used_q + PosW'(1);
  assign depth_m1 = depth_q - CountW'(1);
  assign depth_m2 = depth_q - CountW'(2);

  assign head_val = head_rdv_q ? head_rdata : EmptyPos;
  assign head_b   = same_q ? used_q : head_val;
  assign ent_next = ent_rdata[EntryW-1:NodeW];
  assign ent_nb   = ent_rdata[NodeW-1:0];
  assign take_nb  = !visited_q[ent_nb] && (count_q < CountW'(MaxNodes));

  assign out_valid_o = out_valid_q;
  assign vertex_o    = out_vertex_q;
  assign kind_o      = out_kind_q;
  assign last_o      = out_last_q;

  always_comb begin
    head_we    = 1'b0;
    head_waddr = a_q;
    head_wdata = used_q;
    head_re    = 1'b0;
    head_raddr = first_vertex_i;
    ent_we     = 1'b0;
    ent_waddr  = used_q[EntAddrW-1:0];
    ent_wdata  = {head_val, b_q};
    ent_re     = 1'b0;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    stk_raddr  = depth_m2[NodeW-1:0];
    case (state_q)
      StIdle: begin
        if (in_fire && op_i == OpAddEdge && a_ok && b_ok && !full) begin
          head_re = 1'b1;
        end else if (in_fire && op_i == OpWalk && a_ok) begin
          head_re = 1'b1;
        end
      end
      StEdgeA: begin
        ent_we     = 1'b1;
        head_we    = 1'b1;
        head_re    = 1'b1;
        head_raddr = b_q;
      end
      StEdgeB: begin
        ent_we     = 1'b1;
        ent_waddr  = used_p1[EntAddrW-1:0];
        ent_wdata  = {head_b, a_q};
        head_we    = 1'b1;
        head_waddr = b_q;
        head_wdata = used_p1;
      end
      StPushWait: begin
        stk_we = (depth_q != '0);
      end
      StStep: begin
        if (top_pos_q[PosW-1]) begin
          stk_re = (depth_q != CountW'(1));
        end else begin
          ent_re = 1'b1;
        end
      end
      StEntWait: begin
        if (take_nb && out_free) begin
          head_re    = 1'b1;
          head_raddr = ent_nb;
        end
      end
      default: begin
      end
    endcase
  end

  gdfw_ram #(
    .DataW(PosW),
    .Depth(MaxNodes)
  ) u_head_ram (
    .clk_i  (clk_i),
    .we_i   (head_we),
    .waddr_i(head_waddr),
    .wdata_i(head_wdata),
    .re_i   (head_re),
    .raddr_i(head_raddr),
    .rdata_o(head_rdata)
  );

  gdfw_ram #(
    .DataW(EntryW),
    .Depth(MaxEntries)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .re_i   (ent_re),
    .raddr_i(top_pos_q[EntAddrW-1:0]),
    .rdata_o(ent_rdata)
  );

  gdfw_ram #(
    .DataW(FrameW),
    .Depth(MaxNodes)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(depth_m1[NodeW-1:0]),
    .wdata_i({top_node_q, top_pos_q}),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      vcount_q     <= CountW'(MaxNodes);
      used_q       <= '0;
      head_vld_q   <= '0;
      head_rdv_q   <= 1'b0;
      visited_q    <= '0;
      a_q          <= '0;
      b_q          <= '0;
      same_q       <= 1'b0;
      resp_kind_q  <= KindDone;
      pend_q       <= '0;
      count_q      <= '0;
      depth_q      <= '0;
      new_v_q      <= '0;
      top_node_q   <= '0;
      top_pos_q    <= EmptyPos;
      out_valid_q  <= 1'b0;
      out_vertex_q <= '0;
      out_kind_q   <= KindDone;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        vcount_q <= cfg_data_i;
      end
      if (head_re) begin
        head_rdv_q <= head_vld_q[head_raddr];
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            a_q    <= first_vertex_i;
            b_q    <= second_vertex_i;
            same_q <= (first_vertex_i == second_vertex_i);
            case (op_i)
              OpAddEdge: begin
                if (!(a_ok && b_ok)) begin
                  resp_kind_q <= KindRange;
                  state_q     <= StResp;
                end else if (full) begin
                  resp_kind_q <= KindFull;
                  state_q     <= StResp;
                end else begin
                  state_q <= StEdgeA;
                end
              end
              OpWalk: begin
                if (!a_ok) begin
                  resp_kind_q <= KindRange;
                  state_q     <= StResp;
                end else begin
                  visited_q                 <= '0;
                  visited_q[first_vertex_i] <= 1'b1;
                  pend_q                    <= first_vertex_i;
                  new_v_q                   <= first_vertex_i;
                  count_q                   <= CountW'(1);
                  depth_q                   <= '0;
                  state_q                   <= StPushWait;
                end
              end
              OpClear: begin
                head_vld_q  <= '0;
                used_q      <= '0;
                resp_kind_q <= KindDone;
                state_q     <= StResp;
              end
              default: begin
                resp_kind_q <= KindDone;
                state_q     <= StResp;
              end
            endcase
          end
        end
        StEdgeA: begin
          head_vld_q[a_q] <= 1'b1;
          state_q         <= StEdgeB;
        end
        StEdgeB: begin
          head_vld_q[b_q] <= 1'b1;
          used_q          <= used_q + PosW'(2);
          resp_kind_q     <= KindDone;
          state_q         <= StResp;
        end
        StResp: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_vertex_q <= '0;
            out_kind_q   <= resp_kind_q;
            out_last_q   <= 1'b1;
            state_q      <= StIdle;
          end
        end
        StPushWait: begin
          top_node_q <= new_v_q;
          top_pos_q  <= head_val;
          depth_q    <= depth_q + CountW'(1);
          state_q    <= StStep;
        end
        StStep: begin
          if (!top_pos_q[PosW-1]) begin
            state_q <= StEntWait;
          end else if (depth_q == CountW'(1)) begin
            depth_q <= '0;
            state_q <= StFinish;
          end else begin
            depth_q <= depth_m1;
            state_q <= StPopWait;
          end
        end
        StEntWait: begin
          if (!take_nb) begin
            top_pos_q <= ent_next;
            state_q   <= StStep;
          end else if (out_free) begin
            top_pos_q         <= ent_next;
            out_valid_q       <= 1'b1;
            out_vertex_q      <= pend_q;
            out_kind_q        <= KindVisit;
            out_last_q        <= 1'b0;
            pend_q            <= ent_nb;
            new_v_q           <= ent_nb;
            visited_q[ent_nb] <= 1'b1;
            count_q           <= count_q + CountW'(1);
            state_q           <= StPushWait;
          end
        end
        StPopWait: begin
          top_node_q <= stk_rdata[FrameW-1:PosW];
          top_pos_q  <= stk_rdata[PosW-1:0];
          state_q    <= StStep;
        end
        StFinish: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_vertex_q <= pend_q;
            out_kind_q   <= KindVisit;
            out_last_q   <= 1'b1;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
// Testbench for graph_depth_first_walk: directed and random requests checked against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gdfw_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned CycleLimit = 3000000;
  localparam int LongHold = 400;

  typedef struct packed {
    logic [NodeW-1:0] vertex;
    logic [1:0]       kind;
    logic             last;
  } walk_result_t;

  class walk_scoreboard;
    logic [CountW-1:0] vertex_count;
    logic [PosW-1:0]   head [MaxNodes];
    logic [PosW-1:0]   next_entry [MaxEntries];
    logic [NodeW-1:0]  neighbor [MaxEntries];
    int unsigned       entries_used;
    walk_result_t      expected_q [$];
    int                errors;

    function new();
      vertex_count = CountW'(MaxNodes);
      errors = 0;
      clear_graph();
    endfunction

    function void clear_graph();
      foreach (head[i]) head[i] = EmptyPos;
      entries_used = 0;
    endfunction

    function void link(logic [NodeW-1:0] owner, logic [NodeW-1:0] nb);
      neighbor[entries_used] = nb;
      next_entry[entries_used] = head[owner];
      head[owner] = PosW'(entries_used);
      entries_used++;
    endfunction

    function void push_result(logic [NodeW-1:0] vertex, logic [1:0] kind, logic last);
      walk_result_t r;
      r.vertex = vertex;
      r.kind = kind;
      r.last = last;
      expected_q.push_back(r);
    endfunction

    // The recursion is flattened into a stack of list positions, one per open vertex.
    function void predict_walk(logic [NodeW-1:0] start);
      bit              seen [MaxNodes];
      logic [PosW-1:0] stack_pos [MaxNodes];
      int              depth;
      int              found;
      logic [PosW-1:0] pos;
      logic [NodeW-1:0] nb;
      walk_result_t    r;
      foreach (seen[i]) seen[i] = 1'b0;
      seen[start] = 1'b1;
      push_result(start, KindVisit, 1'b0);
      stack_pos[0] = head[start];
      depth = 1;
      found = 1;
      while (depth > 0) begin
        pos = stack_pos[depth-1];
        if (pos >= PosW'(MaxEntries)) begin
          depth--;
        end else begin
          nb = neighbor[pos[EntAddrW-1:0]];
          stack_pos[depth-1] = next_entry[pos[EntAddrW-1:0]];
          if (!seen[nb] && found < MaxNodes) begin
            seen[nb] = 1'b1;
            push_result(nb, KindVisit, 1'b0);
            found++;
            if (depth < MaxNodes) begin
              stack_pos[depth] = head[nb];
              depth++;
            end
          end
        end
      end
      r = expected_q.pop_back();
      r.last = 1'b1;
      expected_q.push_back(r);
    endfunction

    function void note_request(logic [1:0] op, logic [NodeW-1:0] a, logic [NodeW-1:0] b);
      int unsigned lim;
      lim = (vertex_count > MaxNodes) ? MaxNodes : vertex_count;
      case (op)
        OpAddEdge: begin
          if (a >= lim || b >= lim) begin
            push_result('0, KindRange, 1'b1);
          end else if (entries_used + 2 > MaxEntries) begin
            push_result('0, KindFull, 1'b1);
          end else begin
            link(a, b);
            link(b, a);
            push_result('0, KindDone, 1'b1);
          end
        end
        OpWalk: begin
          if (a >= lim) begin
            push_result('0, KindRange, 1'b1);
          end else begin
            predict_walk(a);
          end
        end
        OpClear: begin
          clear_graph();
          push_result('0, KindDone, 1'b1);
        end
        default: begin
          push_result('0, KindDone, 1'b1);
        end
      endcase
    endfunction

    function void check_result(logic [NodeW-1:0] vertex, logic [1:0] kind, logic last);
      walk_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: vertex %0d kind %0d last %0d", vertex, kind, last);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (vertex !== want.vertex) begin
          $error("vertex: expected %0d, got %0d", want.vertex, vertex);
          errors++;
        end
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        op_i;
  logic [NodeW-1:0]  first_vertex_i;
  logic [NodeW-1:0]  second_vertex_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [NodeW-1:0]  vertex_o;
  logic [1:0]        kind_o;
  logic              last_o;

  walk_scoreboard sb;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_asked = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  int unsigned cycles = 0;

  graph_depth_first_walk DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .first_vertex_i  (first_vertex_i),
    .second_vertex_i (second_vertex_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .vertex_o        (vertex_o),
    .kind_o          (kind_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(vertex_o, kind_o, last_o);
    end
  end

  // The receiver counts its own long hold-off once one is asked for.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = LongHold;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_request(logic [1:0] op, logic [NodeW-1:0] a, logic [NodeW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op;
    first_vertex_i = a;
    second_vertex_i = b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, a, b);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_vertex_count(logic [CountW-1:0] value);
    drain();
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.vertex_count = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [NodeW-1:0] pick_vertex(int lim, int wild_pct);
    if (lim == 0 || $urandom_range(99) < wild_pct) begin
      return NodeW'($urandom_range(MaxNodes - 1));
    end
    return NodeW'($urandom_range(lim - 1));
  endfunction

  task automatic send_random(int lim, int add_pct, int walk_pct, int wild_pct);
    int         roll;
    logic [1:0] op;
    roll = $urandom_range(99);
    if (roll < add_pct) begin
      op = OpAddEdge;
    end else if (roll < add_pct + walk_pct) begin
      op = OpWalk;
    end else if (roll < 98) begin
      op = OpClear;
    end else begin
      op = OpUnused;
    end
    send_request(op, pick_vertex(lim, wild_pct), pick_vertex(lim, wild_pct));
  endtask

  task automatic run_phase(int count, int s_pct, int r_pct, int items, int add_pct,
                           int walk_pct, int wild_pct, bit start_clear);
    int lim;
    write_vertex_count(CountW'(count));
    send_idle_pct = s_pct;
    stall_pct = r_pct;
    lim = (count > MaxNodes) ? MaxNodes : count;
    if (start_clear) begin
      send_request(OpClear, NodeW'($urandom_range(63)), NodeW'($urandom_range(63)));
    end
    repeat (items) send_random(lim, add_pct, walk_pct, wild_pct);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    op_i = OpAddEdge;
    first_vertex_i = '0;
    second_vertex_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Full vertex range: an empty walk, a self loop, chains and the unused op.
    send_request(OpWalk, 6'd0, 6'd0);
    send_request(OpAddEdge, 6'd0, 6'd63);
    send_request(OpAddEdge, 6'd63, 6'd63);
    send_request(OpAddEdge, 6'd0, 6'd5);
    send_request(OpAddEdge, 6'd5, 6'd32);
    send_request(OpAddEdge, 6'd32, 6'd63);
    send_request(OpWalk, 6'd0, 6'd63);
    send_request(OpWalk, 6'd63, 6'd0);
    send_request(OpUnused, 6'd63, 6'd63);

    // A lowered count rejects new vertices but the walk still follows stored edges.
    write_vertex_count(CountW'(10));
    send_request(OpAddEdge, 6'd10, 6'd3);
    send_request(OpAddEdge, 6'd3, 6'd10);
    send_request(OpWalk, 6'd63, 6'd0);
    send_request(OpWalk, 6'd5, 6'd0);
    send_request(OpAddEdge, 6'd9, 6'd9);

    write_vertex_count(CountW'(0));
    send_request(OpAddEdge, 6'd0, 6'd0);
    send_request(OpWalk, 6'd0, 6'd0);
    send_request(OpClear, 6'd63, 6'd63);
    send_request(OpUnused, 6'd0, 6'd0);

    write_vertex_count(CountW'(127));
    send_request(OpWalk, 6'd0, 6'd0);
    send_request(OpAddEdge, 6'd63, 6'd0);
    send_request(OpWalk, 6'd63, 6'd0);

    run_phase(64, 0, 0, 50, 60, 30, 10, 1'b0);
    run_phase(12, 70, 0, 45, 60, 30, 10, 1'b0);
    run_phase(127, 0, 70, 50, 60, 30, 5, 1'b0);
    run_phase(1, 20, 20, 20, 55, 35, 10, 1'b0);
    run_phase(64, 0, 0, 160, 92, 6, 1, 1'b1);
    run_phase(20, 20, 20, 40, 50, 40, 10, 1'b0);

    // The receiver stalls long enough for the block to refuse new requests.
    write_vertex_count(CountW'(64));
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (10) send_random(64, 60, 35, 5);
    hold_asked++;
    repeat (12) send_random(64, 60, 35, 5);
    drain();
    repeat (18) send_random(64, 60, 35, 5);

    drain();
    repeat (40) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
